// ----- hdl/motor_driver_packet_link_assert.svh -----
// Assertion macros used by the motor driver packet link back end.
`ifndef MOTOR_DRIVER_PACKET_LINK_ASSERT_SVH
`define MOTOR_DRIVER_PACKET_LINK_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define MDPL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define MDPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mdpl_pkg.sv -----
// Shared types, codes and constants of the motor driver packet link.
`default_nettype none
package mdpl_pkg;

    localparam int REPLY_BYTES     = 9;
    localparam int RX_STORE        = REPLY_BYTES - 1;
    localparam int RX_IDX_W        = $clog2(RX_STORE);
    localparam int RX_CNT_W        = $clog2(REPLY_BYTES + 1);
    localparam int SET_FRAME_LEN   = 9;
    localparam int GET_FRAME_LEN   = 7;
    localparam int BYTE_IDX_W      = $clog2(SET_FRAME_LEN);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CODE_SET    = 8'h28;
    localparam logic [7:0] CODE_GET    = 8'h29;
    localparam logic [7:0] CODE_REPLY  = 8'h49;
    localparam logic [7:0] KIND_MOTOR  = 8'h4D;
    localparam logic [7:0] REPLY_TYPE_MASK = 8'hCE;

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_REPLY = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] SEL_MOTOR1  = 2'd0;
    localparam logic [1:0] SEL_MOTOR2  = 2'd1;
    localparam logic [1:0] SEL_BOTH    = 2'd2;
    localparam logic [1:0] SEL_INVALID = 2'd3;

    localparam logic [2:0] REG_DEVICE_ADDRESS = 3'd0;
    localparam logic [2:0] REG_VALUE_MIN      = 3'd1;
    localparam logic [2:0] REG_VALUE_MAX      = 3'd2;
    localparam logic [2:0] REG_MOTOR1_ID      = 3'd3;
    localparam logic [2:0] REG_MOTOR2_ID      = 3'd4;
    localparam logic [2:0] REG_BOTH_ID        = 3'd5;

    localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'd128;
    localparam logic [14:0] RST_VALUE_MIN      = 15'h7801; // -2047
    localparam logic [13:0] RST_VALUE_MAX      = 14'd2047;
    localparam logic [6:0]  RST_MOTOR1_ID      = 7'd2;
    localparam logic [6:0]  RST_MOTOR2_ID      = 7'd1;
    localparam logic [6:0]  RST_BOTH_ID        = 7'd42;

    localparam logic RESULT_TX     = 1'b0;
    localparam logic RESULT_REPORT = 1'b1;

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_GET    = 2'd1,
        KIND_REPORT = 2'd2
    } desc_kind_t;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [14:0] value_min;
        logic [13:0] value_max;
        logic [6:0]  motor1_id;
        logic [6:0]  motor2_id;
        logic [6:0]  both_id;
    } cfg_t;

    // One unit of work for the back end: a frame to send or a report to show.
    typedef struct packed {
        desc_kind_t  kind;
        logic [7:0]  addr;
        logic [7:0]  frame_type;
        logic [6:0]  hdr_sum;
        logic [13:0] mag;
        logic [6:0]  tid;
        logic [6:0]  data_sum;
        logic        reply_ok;
        logic        reply_motor;
        logic [1:0]  reply_quantity;
        logic [14:0] telem_value;
    } desc_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        reply_ok;
        logic        reply_motor;
        logic [1:0]  reply_quantity;
        logic [14:0] telem_value;
    } result_t;

endpackage
`default_nettype wire

// ----- hdl/motor_driver_packet_link.sv -----
// Top level of the motor driver packet link: configuration registers and the front/queue/back chain.
//
// Usage:
//   s_ channel: one request per handshake. s_tuser carries the command (set frame, get frame,
//   received reply byte, or none). A set request is clamped to [value_min, value_max] and sent
//   as nine bytes; a get request as seven; an invalid target sends nothing. Reply bytes are
//   collected into nine-byte frames and the ninth byte yields one report.
//   m_ channel: one transmit byte or one reply report per handshake; m_tlast marks the final
//   byte of each transmitted frame, m_tuser tells transmit bytes (0) from reports (1).
//   cfg port: write a register index and value with cfg_wr_en; only write while idle.
// Path: with the back end free, the first result of a request passes the descriptor queue and
//   then the output register before it shows on m_tvalid.
// Throughput: the back end emits one byte per cycle from its output register while m_tready is
//   high; a set frame is nine bytes, a get frame seven and a report a single result. The front
//   end takes a request every cycle while the descriptor queue (QUEUE_DEPTH entries) has room,
//   and reply bytes that complete no frame never reach it.
// Reset: synchronous, active low; clears the queue, the output register valid, the reply byte
//   count and loads the register defaults (address 128, limits -2047..2047, ids 2, 1, 42).
// Stall: while m_tready is low the output holds; the queue fills and then s_tready drops.
`default_nettype none
module motor_driver_packet_link
    import mdpl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_wdata,
    // Request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,  // cmd
    input  wire logic [31:0] s_tdata,  // op_code, target_select, drive_value, rx_byte, rx_first
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tlast,  // tx_last
    output logic             m_tuser,  // result_kind
    output logic [31:0]      m_tdata   // tx_byte, reply_ok, reply_motor, reply_quantity,
                                       // telem_value, zero fill
);

    cfg_t    cfg_reg, cfg_next;
    logic    q_push, q_full, q_head_valid, q_pop;
    desc_t   q_desc, q_head;
    result_t result;

    // Register writes; indexes past the list are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS: cfg_next.device_address = cfg_wdata[7:0];
                REG_VALUE_MIN:      cfg_next.value_min      = cfg_wdata;
                REG_VALUE_MAX:      cfg_next.value_max      = cfg_wdata[13:0];
                REG_MOTOR1_ID:      cfg_next.motor1_id      = cfg_wdata[6:0];
                REG_MOTOR2_ID:      cfg_next.motor2_id      = cfg_wdata[6:0];
                REG_BOTH_ID:        cfg_next.both_id        = cfg_wdata[6:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= RST_DEVICE_ADDRESS;
            cfg_reg.value_min      <= RST_VALUE_MIN;
            cfg_reg.value_max      <= RST_VALUE_MAX;
            cfg_reg.motor1_id      <= RST_MOTOR1_ID;
            cfg_reg.motor2_id      <= RST_MOTOR2_ID;
            cfg_reg.both_id        <= RST_BOTH_ID;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify requests and assemble reply frames.
    mdpl_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_cmd           (s_tuser),
        .s_op_code       (s_tdata[5:0]),
        .s_target_select (s_tdata[7:6]),
        .s_drive_value   (s_tdata[22:8]),
        .s_rx_byte       (s_tdata[30:23]),
        .s_rx_first      (s_tdata[31]),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_desc          (q_desc)
    );

    // Hold pending frames and reports so either side can stall alone.
    mdpl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_desc),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop)
    );

    // Advance one byte per cycle into the output register while m_tready lets it move.
    mdpl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (result)
    );

    assign m_tlast = result.tx_last;
    assign m_tuser = result.kind;
    assign m_tdata = {5'b0, result.telem_value, result.reply_quantity, result.reply_motor,
                      result.reply_ok, result.tx_byte};

endmodule
`default_nettype wire

// ----- hdl/mdpl_front.sv -----
// Front end: accepts requests, builds frame descriptors and assembles reply frames.
`default_nettype none
module mdpl_front
    import mdpl_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [5:0]  s_op_code,
    input  wire logic [1:0]  s_target_select,
    input  wire logic [14:0] s_drive_value,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_rx_first,
    input  wire logic        q_full,
    output logic             q_push,
    output desc_t            q_desc
);

    logic [RX_CNT_W-1:0] reply_count_reg, reply_count_next;
    logic [7:0]          reply_bytes [RX_STORE];

    logic                accept, is_frame, frame_done, rx_store;
    logic [RX_CNT_W-1:0] count_eff;
    logic [6:0]          tid;
    logic signed [14:0]  x, lo, hi, xc;
    logic signed [15:0]  xw, magw;
    logic                neg;
    logic [7:0]          set_type;
    logic [7:0]          r0, r1, r2, r3, r4, r5, r6, r7;
    logic                ok;
    logic [13:0]         rmag;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_frame = (s_cmd == CMD_SET || s_cmd == CMD_GET) && s_target_select != SEL_INVALID;

    // Reply framing: a first-byte mark restarts the count before the byte lands.
    assign count_eff  = s_rx_first ? '0 : reply_count_reg;
    assign frame_done = count_eff >= RX_CNT_W'(RX_STORE);
    assign rx_store   = accept && s_cmd == CMD_REPLY && !frame_done;

    always_comb begin
        unique case (s_target_select)
            SEL_MOTOR1: tid = cfg.motor1_id;
            SEL_MOTOR2: tid = cfg.motor2_id;
            default:    tid = cfg.both_id;
        endcase
    end

    // Clamp, then split into sign and magnitude.
    always_comb begin
        x    = s_drive_value;
        lo   = cfg.value_min;
        hi   = {1'b0, cfg.value_max};
        xc   = (x < lo) ? lo : x;
        xc   = (xc > hi) ? hi : xc;
        neg  = xc[14];
        xw   = {xc[14], xc};
        magw = neg ? (16'sd0 - xw) : xw;
        set_type = {2'b00, s_op_code} + {7'b0, neg};
    end

    // Reply checks over the stored bytes and the closing checksum byte.
    always_comb begin
        r0 = reply_bytes[0];
        r1 = reply_bytes[1];
        r2 = reply_bytes[2];
        r3 = reply_bytes[3];
        r4 = reply_bytes[4];
        r5 = reply_bytes[5];
        r6 = reply_bytes[6];
        r7 = reply_bytes[7];
        ok = r1 == CODE_REPLY
            && {1'b0, 7'(r0 + r1 + r2)} == r3
            && {1'b0, 7'(r4 + r5 + r6 + r7)} == s_rx_byte
            && r6 == KIND_MOTOR
            && (r7 == {1'b0, cfg.motor1_id} || r7 == {1'b0, cfg.motor2_id})
            && (r2 & REPLY_TYPE_MASK) == 8'h00;
        rmag = {r5[6:0], r4[6:0]};
    end

    always_comb begin
        q_desc = '0;
        q_push = 1'b0;
        if (accept && is_frame) begin
            q_push         = 1'b1;
            q_desc.addr    = cfg.device_address;
            q_desc.tid     = tid;
            if (s_cmd == CMD_SET) begin
                q_desc.kind       = KIND_SET;
                q_desc.frame_type = set_type;
                q_desc.hdr_sum    = 7'(cfg.device_address + CODE_SET + set_type);
                q_desc.mag        = magw[13:0];
                q_desc.data_sum   = 7'({1'b0, magw[6:0]} + {1'b0, magw[13:7]}
                                       + KIND_MOTOR + {1'b0, tid});
            end else begin
                q_desc.kind       = KIND_GET;
                q_desc.frame_type = {2'b00, s_op_code};
                q_desc.hdr_sum    = 7'(cfg.device_address + CODE_GET + {2'b00, s_op_code});
                q_desc.data_sum   = 7'(KIND_MOTOR + {1'b0, tid});
            end
        end else if (accept && s_cmd == CMD_REPLY && frame_done) begin
            q_push          = 1'b1;
            q_desc.kind     = KIND_REPORT;
            q_desc.reply_ok = ok;
            if (ok) begin
                q_desc.reply_motor    = r7 == {1'b0, cfg.motor2_id};
                q_desc.reply_quantity = r2[5:4];
                q_desc.telem_value    = r2[0] ? (15'd0 - {1'b0, rmag}) : {1'b0, rmag};
            end
        end
    end

    always_comb begin
        reply_count_next = reply_count_reg;
        if (accept && s_cmd == CMD_REPLY) begin
            reply_count_next = frame_done ? '0 : count_eff + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reply_count_reg <= '0;
        end else begin
            reply_count_reg <= reply_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rx_store) begin
            reply_bytes[count_eff[RX_IDX_W-1:0]] <= s_rx_byte;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/mdpl_queue.sv -----
// Show-ahead descriptor queue between the front and back ends.
`default_nettype none
module mdpl_queue
    import mdpl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire desc_t push_data,
    output logic       full,
    output logic       head_valid,
    output desc_t      head,
    input  wire logic  pop
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t            entries [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/mdpl_back.sv -----
// Back end: walks each descriptor out byte by byte into the output register.
`default_nettype none
`include "motor_driver_packet_link_assert.svh"
module mdpl_back
    import mdpl_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  head_valid,
    input  wire desc_t head,
    output logic       pop,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output result_t    m_result
);

    logic [BYTE_IDX_W-1:0] idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, res;
    logic                  load, last;

    assign load     = head_valid && (!out_valid_reg || m_tready);
    assign pop      = load && last;
    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        res  = '0;
        last = 1'b1;
        unique case (head.kind)
            KIND_SET: begin
                res.kind    = RESULT_TX;
                last        = idx_reg == BYTE_IDX_W'(SET_FRAME_LEN - 1);
                res.tx_last = last;
                unique case (idx_reg)
                    4'd0:    res.tx_byte = head.addr;
                    4'd1:    res.tx_byte = CODE_SET;
                    4'd2:    res.tx_byte = head.frame_type;
                    4'd3:    res.tx_byte = {1'b0, head.hdr_sum};
                    4'd4:    res.tx_byte = {1'b0, head.mag[6:0]};
                    4'd5:    res.tx_byte = {1'b0, head.mag[13:7]};
                    4'd6:    res.tx_byte = KIND_MOTOR;
                    4'd7:    res.tx_byte = {1'b0, head.tid};
                    default: res.tx_byte = {1'b0, head.data_sum};
                endcase
            end
            KIND_GET: begin
                res.kind    = RESULT_TX;
                last        = idx_reg == BYTE_IDX_W'(GET_FRAME_LEN - 1);
                res.tx_last = last;
                unique case (idx_reg)
                    4'd0:    res.tx_byte = head.addr;
                    4'd1:    res.tx_byte = CODE_GET;
                    4'd2:    res.tx_byte = head.frame_type;
                    4'd3:    res.tx_byte = {1'b0, head.hdr_sum};
                    4'd4:    res.tx_byte = KIND_MOTOR;
                    4'd5:    res.tx_byte = {1'b0, head.tid};
                    default: res.tx_byte = {1'b0, head.data_sum};
                endcase
            end
            default: begin
                res.kind           = RESULT_REPORT;
                res.reply_ok       = head.reply_ok;
                res.reply_motor    = head.reply_motor;
                res.reply_quantity = head.reply_quantity;
                res.telem_value    = head.telem_value;
            end
        endcase
    end

    always_comb begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            idx_next       = last ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= res;
        end
    end

    `MDPL_ASSERT_NOW(a_idx_in_frame, 1'b1, idx_reg < BYTE_IDX_W'(SET_FRAME_LEN), "byte index past frame end")
    `MDPL_ASSERT_NEXT(a_idx_wrap, load && last, idx_reg == '0, "byte index not cleared after last byte")
    `MDPL_ASSERT_NOW(a_mid_frame_head, idx_reg != '0, head_valid && head.kind != KIND_REPORT, "frame in progress without a frame at queue head")
    `MDPL_ASSERT_NOW(a_get_len, idx_reg != '0 && head.kind == KIND_GET, idx_reg < BYTE_IDX_W'(GET_FRAME_LEN), "get frame runs past seven bytes")
    `MDPL_ASSERT_NOW(a_report_clean, out_valid_reg && out_reg.kind == RESULT_REPORT, out_reg.tx_byte == 8'h00 && !out_reg.tx_last, "report carries transmit fields")

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the motor driver packet link: frame encoding, clamping and replies.
`timescale 1ns / 1ps
module tb_top;
    import mdpl_pkg::*;

    // Generous ceiling: about 260 requests, up to nine bytes each, every byte stalled,
    // plus sender gaps and the long hold-off.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASE_REQUESTS  = 47;

    // How a request's results are predicted: by the predictor, typed into the table, none, or a failed report.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_BYTES,
        CHK_SILENT,
        CHK_BAD_REPORT
    } row_check_t;

    typedef struct {
        logic [1:0]      cmd;
        logic [5:0]      op_code;
        logic [1:0]      target_sel;
        logic [14:0]     drive_value;
        logic [7:0]      rx_byte;
        logic            rx_first;
        row_check_t      check;
        int              n_bytes;
        logic [0:8][7:0] frame;
    } request_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tlast;
    logic        m_tuser;
    logic [31:0] m_tdata;

    // Predictor state: register copy, partial reply frame and stored telemetry.
    cfg_t        link_cfg;
    logic [7:0]  rx_frame [8];
    logic [3:0]  rx_fill;
    logic [14:0] telemetry [8];

    result_t     pending_results[$];
    result_t     step_results[$];
    request_t    request_q[$];
    request_t    cur_req;

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          long_hold = 0;
    bit          idle_on;
    bit          stall_on;

    motor_driver_packet_link u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic result_t tx_result(input logic [7:0] b, input logic last);
        result_t res;
        res = '0;
        res.kind = RESULT_TX;
        res.tx_byte = b;
        res.tx_last = last;
        return res;
    endfunction

    // Work out what one accepted request produces and advance the predictor state.
    task automatic predict_request(input request_t r);
        int          x;
        int          lo;
        int          hi;
        int          n;
        int          i;
        logic [7:0]  f [9];
        logic [7:0]  ftype;
        logic [7:0]  tid;
        logic [7:0]  code;
        logic [13:0] mag;
        logic        ok;
        result_t     rep;
        step_results.delete();
        if ((r.cmd == CMD_SET || r.cmd == CMD_GET) && r.target_sel != SEL_INVALID) begin
            case (r.target_sel)
                SEL_MOTOR1: tid = {1'b0, link_cfg.motor1_id};
                SEL_MOTOR2: tid = {1'b0, link_cfg.motor2_id};
                default:    tid = {1'b0, link_cfg.both_id};
            endcase
            f[0] = link_cfg.device_address;
            if (r.cmd == CMD_SET) begin
                // Clamp as max against the floor first, so crossed bounds give the ceiling.
                x  = int'($signed(r.drive_value));
                lo = int'($signed(link_cfg.value_min));
                hi = int'(link_cfg.value_max);
                if (x < lo) x = lo;
                if (x > hi) x = hi;
                ftype = {2'b00, r.op_code};
                if (x < 0) begin
                    ftype = ftype + 8'd1;
                    x = -x;
                end
                mag  = 14'(x);
                f[1] = CODE_SET;
                f[2] = ftype;
                f[3] = (f[0] + CODE_SET + ftype) & 8'h7F;
                f[4] = {1'b0, mag[6:0]};
                f[5] = {1'b0, mag[13:7]};
                f[6] = KIND_MOTOR;
                f[7] = tid;
                f[8] = (f[4] + f[5] + f[6] + f[7]) & 8'h7F;
                n = SET_FRAME_LEN;
            end else begin
                f[1] = CODE_GET;
                f[2] = {2'b00, r.op_code};
                f[3] = (f[0] + CODE_GET + f[2]) & 8'h7F;
                f[4] = KIND_MOTOR;
                f[5] = tid;
                f[6] = (KIND_MOTOR + tid) & 8'h7F;
                n = GET_FRAME_LEN;
            end
            for (i = 0; i < n; i++) begin
                step_results.push_back(tx_result(f[i], i == n - 1));
            end
        end else if (r.cmd == CMD_REPLY) begin
            if (r.rx_first) rx_fill = '0;
            if (rx_fill < RX_STORE) begin
                rx_frame[rx_fill[2:0]] = r.rx_byte;
                rx_fill = rx_fill + 4'd1;
            end else begin
                rx_fill = '0;
                code = rx_frame[2];
                ok = rx_frame[1] == CODE_REPLY
                  && ((rx_frame[0] + rx_frame[1] + rx_frame[2]) & 8'h7F) == rx_frame[3]
                  && ((rx_frame[4] + rx_frame[5] + rx_frame[6] + rx_frame[7]) & 8'h7F)
                     == r.rx_byte
                  && rx_frame[6] == KIND_MOTOR
                  && (rx_frame[7] == {1'b0, link_cfg.motor1_id}
                      || rx_frame[7] == {1'b0, link_cfg.motor2_id})
                  && (code & REPLY_TYPE_MASK) == 8'h00;
                rep = '0;
                rep.kind = RESULT_REPORT;
                rep.reply_ok = ok;
                if (ok) begin
                    // Motor two wins when both ids match.
                    rep.reply_motor = (rx_frame[7] == {1'b0, link_cfg.motor2_id});
                    rep.reply_quantity = code[5:4];
                    rep.telem_value = {1'b0, rx_frame[5][6:0], rx_frame[4][6:0]};
                    if (code[0]) rep.telem_value = -rep.telem_value;
                    telemetry[{rep.reply_motor, rep.reply_quantity}] = rep.telem_value;
                end
                step_results.push_back(rep);
            end
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Scoreboard: queue predictions on the request side, then check the result side,
    // both at the same edge in a fixed order.
    always @(posedge aclk) begin : link_scoreboard
        result_t got;
        result_t want;
        int      i;
        if (aresetn && s_tvalid && s_tready) begin
            predict_request(cur_req);
            case (cur_req.check)
                CHK_MODEL: begin
                    foreach (step_results[k]) pending_results.push_back(step_results[k]);
                end
                CHK_BYTES: begin
                    for (i = 0; i < cur_req.n_bytes; i++) begin
                        pending_results.push_back(
                            tx_result(cur_req.frame[i], i == cur_req.n_bytes - 1));
                    end
                end
                CHK_BAD_REPORT: begin
                    want = '0;
                    want.kind = RESULT_REPORT;
                    pending_results.push_back(want);
                end
                default: ;
            endcase
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.kind           = m_tuser;
            got.tx_byte        = m_tdata[7:0];
            got.tx_last        = m_tlast;
            got.reply_ok       = m_tdata[8];
            got.reply_motor    = m_tdata[9];
            got.reply_quantity = m_tdata[11:10];
            got.telem_value    = m_tdata[26:12];
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d byte 0x%0h, nothing pending",
                       got.kind, got.tx_byte);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", want.kind, got.kind);
                check_field("tx_byte", want.tx_byte, got.tx_byte);
                check_field("tx_last", want.tx_last, got.tx_last);
                check_field("reply_ok", want.reply_ok, got.reply_ok);
                check_field("reply_motor", want.reply_motor, got.reply_motor);
                check_field("reply_quantity", want.reply_quantity, got.reply_quantity);
                check_field("telem_value", want.telem_value, got.telem_value);
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold > 0) begin
                m_tready <= 1'b0;
                repeat (long_hold) @(negedge aclk);
                long_hold = 0;
                m_tready <= 1'b1;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Table row outside the reply path; the ignored reply fields get random content.
    task automatic add_row(input logic [1:0] cmd, input logic [5:0] op, input logic [1:0] sel,
                           input logic [14:0] val, input row_check_t check, input int n,
                           input logic [0:8][7:0] fr);
        request_t r;
        r.cmd         = cmd;
        r.op_code     = op;
        r.target_sel  = sel;
        r.drive_value = val;
        r.rx_byte     = 8'($urandom);
        r.rx_first    = 1'($urandom);
        r.check       = check;
        r.n_bytes     = n;
        r.frame       = fr;
        request_q.push_back(r);
    endtask

    // Queue the first n bytes of a reply frame, first byte flagged as frame start.
    task automatic push_reply_frame(input logic [0:8][7:0] fr, input int n,
                                    input row_check_t last_check);
        request_t r;
        int       i;
        for (i = 0; i < n; i++) begin
            r.cmd         = CMD_REPLY;
            r.op_code     = 6'($urandom);
            r.target_sel  = 2'($urandom);
            r.drive_value = 15'($urandom);
            r.rx_byte     = fr[i];
            r.rx_first    = (i == 0);
            r.check       = (i == n - 1) ? last_check : CHK_MODEL;
            r.n_bytes     = 0;
            r.frame       = '0;
            request_q.push_back(r);
        end
    endtask

    // Mostly well-formed reply frame for the current ids; now and then a bad type,
    // a foreign target or one flipped bit.
    function automatic logic [0:8][7:0] random_reply_frame();
        logic [0:8][7:0] fr;
        fr[0] = 8'($urandom);
        fr[1] = CODE_REPLY;
        fr[2] = {2'b00, 2'($urandom), 3'b000, 1'($urandom)};
        if ($urandom_range(0, 7) == 0) fr[2] = 8'($urandom);
        fr[3] = (fr[0] + fr[1] + fr[2]) & 8'h7F;
        fr[4] = 8'($urandom);
        fr[5] = 8'($urandom);
        fr[6] = KIND_MOTOR;
        case ($urandom_range(0, 5))
            0, 1:    fr[7] = {1'b0, link_cfg.motor1_id};
            2, 3:    fr[7] = {1'b0, link_cfg.motor2_id};
            4:       fr[7] = {1'b0, link_cfg.both_id};
            default: fr[7] = 8'($urandom);
        endcase
        fr[8] = (fr[4] + fr[5] + fr[6] + fr[7]) & 8'h7F;
        if ($urandom_range(0, 5) == 0) fr[$urandom_range(0, 8)] ^= 8'(1 << $urandom_range(0, 7));
        return fr;
    endfunction

    // Random mix: set and get requests, reply frames, and some noise. Requests that the
    // block drops (command none, invalid target) are not counted.
    task automatic queue_random_requests(input int count);
        request_t r;
        int       made;
        int       v;
        made = 0;
        while (made < count) begin
            r.op_code     = 6'($urandom);
            r.target_sel  = 2'($urandom);
            r.drive_value = 15'($urandom);
            r.rx_byte     = 8'($urandom);
            r.rx_first    = 1'($urandom);
            r.check       = CHK_MODEL;
            r.n_bytes     = 0;
            r.frame       = '0;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    r.cmd = CMD_SET;
                    // Aim a good share at the clamp edges and around zero.
                    case ($urandom_range(0, 3))
                        0:       v = int'($signed(link_cfg.value_min)) + $urandom_range(0, 2) - 1;
                        1:       v = int'(link_cfg.value_max) + $urandom_range(0, 2) - 1;
                        2:       v = $urandom_range(0, 6) - 3;
                        default: v = $urandom;
                    endcase
                    r.drive_value = 15'(v);
                    request_q.push_back(r);
                    if (r.target_sel != SEL_INVALID) made++;
                end
                3, 4: begin
                    r.cmd = CMD_GET;
                    request_q.push_back(r);
                    if (r.target_sel != SEL_INVALID) made++;
                end
                5, 6, 7, 8: begin
                    push_reply_frame(random_reply_frame(), REPLY_BYTES, CHK_MODEL);
                    made += REPLY_BYTES;
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: begin
                            r.cmd = CMD_NONE;
                            request_q.push_back(r);
                        end
                        1: begin
                            // Lone byte, random frame-start flag.
                            r.cmd = CMD_REPLY;
                            request_q.push_back(r);
                            made++;
                        end
                        default: begin
                            // Cut-off frame; the next frame start must resync.
                            v = $urandom_range(1, RX_STORE);
                            push_reply_frame(random_reply_frame(), v, CHK_MODEL);
                            made += v;
                        end
                    endcase
                end
            endcase
        end
    endtask

    // Drive queued requests at the falling edge; hold each until its handshake.
    task automatic send_requests();
        request_t r;
        while (request_q.size() > 0) begin
            r = request_q.pop_front();
            if (idle_on && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            cur_req = r;
            s_tuser  <= r.cmd;
            s_tdata  <= {r.rx_first, r.rx_byte, r.drive_value, r.target_sel, r.op_code};
            s_tvalid <= 1'b1;
            do @(posedge aclk); while (!s_tready);
            @(negedge aclk);
        end
        s_tvalid <= 1'b0;
    endtask

    // Wait for every expected result, then let trailing reply bytes settle.
    task automatic wait_link_idle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_DEVICE_ADDRESS: link_cfg.device_address = data[7:0];
            REG_VALUE_MIN:      link_cfg.value_min      = data[14:0];
            REG_VALUE_MAX:      link_cfg.value_max      = data[13:0];
            REG_MOTOR1_ID:      link_cfg.motor1_id      = data[6:0];
            REG_MOTOR2_ID:      link_cfg.motor2_id      = data[6:0];
            REG_BOTH_ID:        link_cfg.both_id        = data[6:0];
            default: ;
        endcase
    endtask

    // Rewrite every register, then drop the write enable.
    task automatic program_link(input logic [7:0] addr, input logic [14:0] vmin,
                                input logic [13:0] vmax, input logic [6:0] id1,
                                input logic [6:0] id2, input logic [6:0] idb);
        write_reg(REG_DEVICE_ADDRESS, {7'd0, addr});
        write_reg(REG_VALUE_MIN, vmin);
        write_reg(REG_VALUE_MAX, {1'b0, vmax});
        write_reg(REG_MOTOR1_ID, {8'd0, id1});
        write_reg(REG_MOTOR2_ID, {8'd0, id2});
        write_reg(REG_BOTH_ID, {8'd0, idb});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] addr, input logic [14:0] vmin,
                             input logic [13:0] vmax, input logic [6:0] id1,
                             input logic [6:0] id2, input logic [6:0] idb, input int hold);
        program_link(addr, vmin, vmax, id1, id2, idb);
        queue_random_requests(PHASE_REQUESTS);
        long_hold = hold;
        send_requests();
        wait_link_idle();
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_DEVICE_ADDRESS;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_NONE;
        s_tdata   <= '0;
        idle_on  = 1'b1;
        stall_on = 1'b1;

        link_cfg.device_address = RST_DEVICE_ADDRESS;
        link_cfg.value_min      = RST_VALUE_MIN;
        link_cfg.value_max      = RST_VALUE_MAX;
        link_cfg.motor1_id      = RST_MOTOR1_ID;
        link_cfg.motor2_id      = RST_MOTOR2_ID;
        link_cfg.both_id        = RST_BOTH_ID;
        rx_fill = '0;
        foreach (rx_frame[k]) rx_frame[k] = '0;
        foreach (telemetry[k]) telemetry[k] = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table under reset defaults: address 128, clamp -2047..2047,
        // ids 2, 1 and 42. Frames that are easy to read off are typed in.
        add_row(CMD_SET, 6'd0, SEL_MOTOR1, 15'd0, CHK_BYTES, SET_FRAME_LEN,
                {8'd128, CODE_SET, 8'd0, 8'd40, 8'd0, 8'd0, KIND_MOTOR, 8'd2, 8'd79});
        // Full positive value clamps to 2047.
        add_row(CMD_SET, 6'd0, SEL_MOTOR1, 15'h3FFF, CHK_BYTES, SET_FRAME_LEN,
                {8'd128, CODE_SET, 8'd0, 8'd40, 8'd127, 8'd15, KIND_MOTOR, 8'd2, 8'd93});
        // Full negative value clamps to -2047; the type gets the sign bump.
        add_row(CMD_SET, 6'd16, SEL_MOTOR2, 15'h4001, CHK_BYTES, SET_FRAME_LEN,
                {8'd128, CODE_SET, 8'd17, 8'd57, 8'd127, 8'd15, KIND_MOTOR, 8'd1, 8'd92});
        // Top type code with the sign bump, both motors.
        add_row(CMD_SET, 6'd63, SEL_BOTH, 15'h7FFF, CHK_BYTES, SET_FRAME_LEN,
                {8'd128, CODE_SET, 8'd64, 8'd104, 8'd1, 8'd0, KIND_MOTOR, 8'd42, 8'd120});
        // Invalid target sends nothing.
        add_row(CMD_SET, 6'd48, SEL_INVALID, 15'd5, CHK_SILENT, 0, '0);
        add_row(CMD_GET, 6'd0, SEL_MOTOR1, 15'd0, CHK_BYTES, GET_FRAME_LEN,
                {8'd128, CODE_GET, 8'd0, 8'd41, KIND_MOTOR, 8'd2, 8'd79, 8'd0, 8'd0});
        add_row(CMD_GET, 6'd32, SEL_MOTOR2, 15'd0, CHK_BYTES, GET_FRAME_LEN,
                {8'd128, CODE_GET, 8'd32, 8'd73, KIND_MOTOR, 8'd1, 8'd78, 8'd0, 8'd0});
        add_row(CMD_GET, 6'd63, SEL_BOTH, 15'h7FFF, CHK_MODEL, 0, '0);
        // Command none is dropped.
        add_row(CMD_NONE, 6'd63, SEL_MOTOR1, 15'h4000, CHK_SILENT, 0, '0);
        // Good reply: motor two, largest negative magnitude.
        push_reply_frame({8'd128, CODE_REPLY, 8'h11, 8'd90, 8'h7F, 8'h7F, KIND_MOTOR,
                          8'd1, 8'd76}, REPLY_BYTES, CHK_MODEL);
        // Wrong reply code with both checksums right: failed report, all zero.
        push_reply_frame({8'd0, CODE_REPLY ^ 8'h01, 8'h31, 8'd121, 8'd0, 8'd0, KIND_MOTOR,
                          8'd2, 8'd79}, REPLY_BYTES, CHK_BAD_REPORT);
        send_requests();
        wait_link_idle();

        // Clamp -16383..16383, zero and top ids; the receiver holds off while requests pile up.
        run_phase(8'h00, 15'h4001, 14'h3FFF, 7'd0, 7'd127, 7'd5, HOLD_OFF_CYCLES);
        // Clamp pinned at zero, top address.
        run_phase(8'hFF, 15'h0000, 14'h0000, 7'h7F, 7'h00, 7'h7F, 0);
        // Floor at -16384 so the magnitude spills past 14 bits; both motor ids equal.
        run_phase(8'h5A, 15'h4000, 14'h3FFF, 7'd3, 7'd3, 7'd9, 0);
        // Crossed bounds: floor above ceiling.
        run_phase(8'hA5, 15'd300, 14'd200, 7'd7, 7'd8, 7'd9, 0);
        // Back to defaults, full rate on both sides for the closing stretch.
        idle_on  = 1'b0;
        stall_on = 1'b0;
        run_phase(RST_DEVICE_ADDRESS, RST_VALUE_MIN, RST_VALUE_MAX,
                  RST_MOTOR1_ID, RST_MOTOR2_ID, RST_BOTH_ID, 0);

        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- motor_driver_packet_link.f -----
+incdir+hdl
hdl/mdpl_pkg.sv
hdl/mdpl_front.sv
hdl/mdpl_queue.sv
hdl/mdpl_back.sv
hdl/motor_driver_packet_link.sv
dv/tb_top.sv
